// ===== design/rbb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_pkg
// shared types and constants of the rotated bitmap blitter
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int MAX_WIDTH_DEF  = 16;
    localparam int MAX_HEIGHT_DEF = 64;
    localparam int RING_ROWS_DEF  = 64;

    // columns held by the scan register, two code bits each
    localparam int COLS      = 16;
    localparam int CODE_BITS = 2 * COLS;

    typedef struct packed {
        logic [31:0] row_bits;
        logic        first_row;
    } in_item_t;

    typedef struct packed {
        logic signed [9:0] pixel_x;
        logic signed [7:0] pixel_y;
        logic [23:0]       pixel_color;
        logic              last_in_row;
    } out_item_t;

    typedef enum logic [2:0] {
        CFG_TWO_BIT_MODE    = 3'd0,
        CFG_ROTATION        = 3'd1,
        CFG_WIDTH           = 3'd2,
        CFG_HEIGHT          = 3'd3,
        CFG_ORIGIN_X        = 3'd4,
        CFG_ORIGIN_Y        = 3'd5,
        CFG_COLOR_ONE       = 3'd6,
        CFG_COLOR_TWO_THREE = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ROT_NONE  = 3'd0,
        ROT_90    = 3'd1,
        ROT_180   = 3'd2,
        ROT_270   = 3'd3,
        ROT_FLIPX = 3'd4,
        ROT_FLIPY = 3'd5
    } rot_t;

    typedef enum logic [1:0] {
        STEP_ZERO = 2'd0,
        STEP_INC  = 2'd1,
        STEP_DEC  = 2'd2
    } step_t;

    typedef enum logic [1:0] {
        CODE_CLEAR = 2'd0,
        CODE_ONE   = 2'd1,
        CODE_TWO   = 2'd2,
        CODE_THREE = 2'd3
    } code_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

    // per-row start point handed from the setup logic to the scan loop
    typedef struct packed {
        logic [CODE_BITS-1:0] codes;
        logic [9:0]           x0;
        logic [7:0]           y0;
        step_t                dx;
        step_t                dy;
        logic                 skip;
    } setup_t;

endpackage
`default_nettype wire

// ===== design/rbb_setup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rbb_setup
// row setup: pixel code extraction, row clipping and start coordinates
// ----------------------------------------------------------------------------
module rbb_setup #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF,
    parameter int RING_ROWS  = rbb_pkg::RING_ROWS_DEF
) (
    input  wire logic          two_bit_mode,
    input  wire logic [2:0]    rotation,
    input  wire logic [4:0]    width,
    input  wire logic [6:0]    height,
    input  wire logic [8:0]    origin_x,
    input  wire logic [6:0]    origin_y,
    input  wire logic [31:0]   row_bits,
    input  wire logic [5:0]    ry,
    output rbb_pkg::setup_t    setup
);
    import rbb_pkg::*;

    localparam logic [4:0] W_MAX = 5'(MAX_WIDTH);
    localparam int         H_CAP = (MAX_HEIGHT > 127) ? 127 : MAX_HEIGHT;
    localparam logic [6:0] H_MAX = 7'(H_CAP);
    localparam logic signed [9:0] RING = 10'(RING_ROWS);

    logic [4:0]        w;
    logic [6:0]        h;
    logic signed [9:0] ring_row;
    logic [5:0]        shamt;
    logic [31:0]       aligned;
    logic [CODE_BITS-1:0] codes;
    logic [9:0]        ox10;
    logic [9:0]        ry10;
    logic [9:0]        wm1_10;
    logic [9:0]        hr10;
    logic [7:0]        oy8;
    logic [7:0]        ry8;
    logic [7:0]        wm1_8;
    logic [7:0]        hr8;

    assign w = (width > W_MAX) ? W_MAX : width;
    assign h = (height > H_MAX) ? H_MAX : height;

    assign ring_row = {{3{origin_y[6]}}, origin_y} + {4'b0, ry};

    // left-justify the 2bpp pixels so column c sits at bits 31-2c
    assign shamt   = 6'd32 - {w, 1'b0};
    assign aligned = row_bits << shamt;

    always_comb
    begin
        for (int c = 0; c < COLS; c++)
        begin
            if (5'(c) >= w)
                codes[2*c +: 2] = CODE_CLEAR;
            else if (two_bit_mode)
                codes[2*c +: 2] = aligned[31-2*c -: 2];
            else
                codes[2*c +: 2] = {1'b0, row_bits[c]};
        end
    end

    assign ox10   = {origin_x[8], origin_x};
    assign ry10   = {4'b0, ry};
    assign wm1_10 = {5'b0, w} - 10'd1;
    assign hr10   = {3'b0, h} - ry10 - 10'd1;
    assign oy8    = {origin_y[6], origin_y};
    assign ry8    = {2'b0, ry};
    assign wm1_8  = {3'b0, w} - 8'd1;
    assign hr8    = {1'b0, h} - ry8 - 8'd1;

    always_comb
    begin
        setup.codes = codes;
        setup.skip  = ({1'b0, ry} >= h) || (ring_row >= RING);
        case (rotation)
            ROT_90:
            begin
                setup.x0 = ox10 + ry10;    setup.dx = STEP_ZERO;
                setup.y0 = oy8 + wm1_8;    setup.dy = STEP_DEC;
            end
            ROT_180:
            begin
                setup.x0 = ox10 + wm1_10;  setup.dx = STEP_DEC;
                setup.y0 = oy8 + hr8;      setup.dy = STEP_ZERO;
            end
            ROT_270:
            begin
                setup.x0 = ox10 + hr10;    setup.dx = STEP_ZERO;
                setup.y0 = oy8;            setup.dy = STEP_INC;
            end
            ROT_FLIPX:
            begin
                setup.x0 = ox10;           setup.dx = STEP_INC;
                setup.y0 = oy8 + hr8;      setup.dy = STEP_ZERO;
            end
            ROT_FLIPY:
            begin
                setup.x0 = ox10 + wm1_10;  setup.dx = STEP_DEC;
                setup.y0 = oy8 + ry8;      setup.dy = STEP_ZERO;
            end
            default:
            begin
                setup.x0 = ox10;           setup.dx = STEP_INC;
                setup.y0 = oy8 + ry8;      setup.dy = STEP_ZERO;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== design/rotated_bitmap_blitter.sv =====
`default_nettype none
// path: a drawn column goes from the scan registers into the output register when it is emitted
// throughput: one column per cycle, unless the pixel output stalls, through the x/y step logic;
//   a row scans each column up to its last drawn pixel, and no new row is taken until it is done
// rows with no drawn pixels, and clipped rows, are taken without a scan
// reset: asynchronous active-low, restores register defaults and row index zero
// ----------------------------------------------------------------------------
// rotated_bitmap_blitter
// turns bitmap row words into rotated pixel writes; without stalls, one column per cycle
// ----------------------------------------------------------------------------
module rotated_bitmap_blitter #(
    parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF,
    parameter int RING_ROWS  = rbb_pkg::RING_ROWS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_addr,
    input  wire logic [47:0]       cfg_wdata,
    input  wire logic              row_valid,
    output logic                   row_ready,
    input  wire rbb_pkg::in_item_t row_item,
    output logic                   pix_valid,
    input  wire logic              pix_ready,
    output rbb_pkg::out_item_t     pix_item
);
    import rbb_pkg::*;

    logic        two_bit_mode_reg;
    logic [2:0]  rotation_reg;
    logic [4:0]  width_reg;
    logic [6:0]  height_reg;
    logic [8:0]  origin_x_reg;
    logic [6:0]  origin_y_reg;
    logic [23:0] color_one_reg;
    logic [47:0] color_two_three_reg;

    state_t               state_reg, state_next;
    logic [5:0]           row_index_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic [9:0]           x_reg;
    logic [7:0]           y_reg;
    step_t                dx_reg, dy_reg;
    out_item_t            out_reg;
    logic                 out_valid_reg;

    logic [5:0] ry;
    setup_t     setup;
    logic       row_xfer;
    logic       advance;
    logic       emit;
    logic       last;
    logic       start;
    logic [23:0] color;

    assign ry = row_item.first_row ? 6'd0 : row_index_reg;

    rbb_setup #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .RING_ROWS  (RING_ROWS)
    ) u_setup (
        .two_bit_mode (two_bit_mode_reg),
        .rotation     (rotation_reg),
        .width        (width_reg),
        .height       (height_reg),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .row_bits     (row_item.row_bits),
        .ry           (ry),
        .setup        (setup)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_bit_mode_reg    <= 1'b0;
            rotation_reg        <= ROT_NONE;
            width_reg           <= 5'd16;
            height_reg          <= 7'd16;
            origin_x_reg        <= 9'd0;
            origin_y_reg        <= 7'd0;
            color_one_reg       <= 24'hFFFFFF;
            color_two_three_reg <= 48'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_TWO_BIT_MODE:    two_bit_mode_reg    <= cfg_wdata[0];
                CFG_ROTATION:        rotation_reg        <= cfg_wdata[2:0];
                CFG_WIDTH:           width_reg           <= cfg_wdata[4:0];
                CFG_HEIGHT:          height_reg          <= cfg_wdata[6:0];
                CFG_ORIGIN_X:        origin_x_reg        <= cfg_wdata[8:0];
                CFG_ORIGIN_Y:        origin_y_reg        <= cfg_wdata[6:0];
                CFG_COLOR_ONE:       color_one_reg       <= cfg_wdata[23:0];
                CFG_COLOR_TWO_THREE: color_two_three_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_RUN;
            ST_RUN:
                if (advance && last)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        row_ready = 1'b0;
        advance   = 1'b0;
        case (state_reg)
            ST_IDLE: row_ready = 1'b1;
            ST_RUN:  advance   = !out_valid_reg || pix_ready;
            default: ;
        endcase
    end

    assign row_xfer = row_valid && row_ready;
    assign start    = row_xfer && !setup.skip && (setup.codes != '0);
    assign emit     = advance && (code_reg[1:0] != CODE_CLEAR);
    assign last     = (code_reg[CODE_BITS-1:2] == '0);

    always_comb
    begin
        case (code_reg[1:0])
            CODE_TWO:   color = color_two_three_reg[23:0];
            CODE_THREE: color = color_two_three_reg[47:24];
            default:    color = color_one_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_index_reg <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (row_xfer)
                row_index_reg <= ry + 6'd1;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (pix_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // scan registers: one column per cycle, unless the pixel output stalls, through the x/y step logic
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            code_reg <= setup.codes;
            x_reg    <= setup.x0;
            y_reg    <= setup.y0;
            dx_reg   <= setup.dx;
            dy_reg   <= setup.dy;
        end
        else if (advance)
        begin
            code_reg <= code_reg >> 2;
            case (dx_reg)
                STEP_INC: x_reg <= x_reg + 10'd1;
                STEP_DEC: x_reg <= x_reg - 10'd1;
                default:  x_reg <= x_reg;
            endcase
            case (dy_reg)
                STEP_INC: y_reg <= y_reg + 8'd1;
                STEP_DEC: y_reg <= y_reg - 8'd1;
                default:  y_reg <= y_reg;
            endcase
        end
        if (emit)
        begin
            out_reg.pixel_x     <= x_reg;
            out_reg.pixel_y     <= y_reg;
            out_reg.pixel_color <= color;
            out_reg.last_in_row <= last;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix_item  = out_reg;

    // a running row always has a pixel left to draw
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> code_reg != '0)
        else $error("scan running with no pixels left");

    // the last pixel of a row leaves the scan and frees the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        emit && last |=> state_reg == ST_IDLE && pix_valid && pix_item.last_in_row)
        else $error("row end not flagged or scan did not stop");

    // row counter follows the row that was just taken
    assert property (@(posedge clk) disable iff (!rst_n)
        row_xfer |=> row_index_reg == $past(ry) + 6'd1)
        else $error("row index not advanced");

    // a write only appears out of the scan loop
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(state_reg == ST_RUN))
        else $error("pixel write outside of a row scan");

endmodule
`default_nettype wire

// ===== bench/rbb_checker.sv =====
// ----------------------------------------------------------------------------
// rbb_checker
// Watches the register port and both channels of the rotated bitmap blitter.
// It keeps its own copy of the registers and the row counter, works out the
// pixel writes of each row transfer and compares every pixel write against
// the oldest one still owed. The failure count goes back to the testbench.
// ----------------------------------------------------------------------------
module rbb_checker
    import rbb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    input  logic        row_valid,
    input  logic        row_ready,
    input  in_item_t    row_item,
    input  logic        pix_valid,
    input  logic        pix_ready,
    input  out_item_t   pix_item,
    output int          fail_count,
    output int          writes_pending,
    output int          writes_checked
);

    localparam int WIDTH_CAP  = 16;
    localparam int HEIGHT_CAP = 64;
    localparam int RING_ROWS  = 64;
    localparam int REPORT_MAX = 10;

    logic              two_bit;
    logic [2:0]        rot_code;
    logic [4:0]        bmp_width;
    logic [6:0]        bmp_height;
    logic signed [8:0] org_x;
    logic signed [6:0] org_y;
    logic [23:0]       color1;
    logic [47:0]       color23;
    logic [5:0]        next_row;
    out_item_t         owed_writes[$];
    int                n_fail;
    int                n_checked;

    // 1bpp reads bit rx, 2bpp reads the code pair MSB first
    function automatic logic [1:0] pixel_code(input logic [31:0] bits, input int rx,
                                              input int w);
        if (two_bit)
            return bits[2*w - 2 - 2*rx +: 2];
        return {1'b0, bits[rx]};
    endfunction

    task automatic predict_row_writes(input in_item_t item);
        int        ry;
        int        w;
        int        h;
        int        ox;
        int        oy;
        int        x;
        int        y;
        int        last_rx;
        logic [1:0] code;
        out_item_t wr;
        ry = item.first_row ? 0 : int'(next_row);
        w  = (bmp_width > WIDTH_CAP) ? WIDTH_CAP : int'(bmp_width);
        h  = (bmp_height > HEIGHT_CAP) ? HEIGHT_CAP : int'(bmp_height);
        ox = org_x;
        oy = org_y;
        next_row = 6'(ry + 1);
        // rows past the bitmap and rows that fall off the ring draw nothing
        if (ry >= h || oy + ry >= RING_ROWS)
            return;
        last_rx = -1;
        for (int rx = 0; rx < w; rx++)
            if (pixel_code(item.row_bits, rx, w) != CODE_CLEAR)
                last_rx = rx;
        for (int rx = 0; rx < w; rx++)
        begin
            code = pixel_code(item.row_bits, rx, w);
            if (code == CODE_CLEAR)
                continue;
            case (code)
                CODE_ONE: wr.pixel_color = color1;
                CODE_TWO: wr.pixel_color = color23[23:0];
                default:  wr.pixel_color = color23[47:24];
            endcase
            case (rot_code)
                ROT_90:
                begin
                    x = ox + ry;
                    y = oy + w - rx - 1;
                end
                ROT_180:
                begin
                    x = ox + w - rx - 1;
                    y = oy + h - ry - 1;
                end
                ROT_270:
                begin
                    x = ox + h - ry - 1;
                    y = oy + rx;
                end
                ROT_FLIPX:
                begin
                    x = ox + rx;
                    y = oy + h - ry - 1;
                end
                ROT_FLIPY:
                begin
                    x = ox + w - rx - 1;
                    y = oy + ry;
                end
                default:
                begin
                    x = ox + rx;
                    y = oy + ry;
                end
            endcase
            wr.pixel_x     = x[9:0];
            wr.pixel_y     = y[7:0];
            wr.last_in_row = (rx == last_rx);
            owed_writes.push_back(wr);
        end
    endtask

    task automatic check_pixel_write(input out_item_t got);
        out_item_t want;
        if (owed_writes.size() == 0)
        begin
            n_fail++;
            if (n_fail <= REPORT_MAX)
                $display("unexpected pixel write: x=%0d y=%0d color=%06h last=%0b",
                         got.pixel_x, got.pixel_y, got.pixel_color, got.last_in_row);
            return;
        end
        want = owed_writes.pop_front();
        n_checked++;
        if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
            got.pixel_color !== want.pixel_color || got.last_in_row !== want.last_in_row)
        begin
            n_fail++;
            if (n_fail <= REPORT_MAX)
            begin
                $display("pixel write %0d mismatch", n_checked);
                $display("  expected x=%0d y=%0d color=%06h last=%0b",
                         want.pixel_x, want.pixel_y, want.pixel_color, want.last_in_row);
                $display("  actual   x=%0d y=%0d color=%06h last=%0b",
                         got.pixel_x, got.pixel_y, got.pixel_color, got.last_in_row);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            two_bit    = 1'b0;
            rot_code   = ROT_NONE;
            bmp_width  = 5'd16;
            bmp_height = 7'd16;
            org_x      = '0;
            org_y      = '0;
            color1     = 24'hFFFFFF;
            color23    = '0;
            next_row   = '0;
            owed_writes.delete();
            n_fail     = 0;
            n_checked  = 0;
        end
        else
        begin
            // a row and one of its own writes never share an edge
            if (row_valid && row_ready)
                predict_row_writes(row_item);
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_TWO_BIT_MODE:    two_bit    = cfg_wdata[0];
                    CFG_ROTATION:        rot_code   = cfg_wdata[2:0];
                    CFG_WIDTH:           bmp_width  = cfg_wdata[4:0];
                    CFG_HEIGHT:          bmp_height = cfg_wdata[6:0];
                    CFG_ORIGIN_X:        org_x      = cfg_wdata[8:0];
                    CFG_ORIGIN_Y:        org_y      = cfg_wdata[6:0];
                    CFG_COLOR_ONE:       color1     = cfg_wdata[23:0];
                    CFG_COLOR_TWO_THREE: color23    = cfg_wdata;
                    default: ;
                endcase
            end
            if (pix_valid && pix_ready)
                check_pixel_write(pix_item);
        end
        fail_count     <= n_fail;
        writes_pending <= owed_writes.size();
        writes_checked <= n_checked;
    end

endmodule

// ===== bench/tb_rotated_bitmap_blitter.sv =====
// ----------------------------------------------------------------------------
// tb_rotated_bitmap_blitter
// Drives register settings and bitmap rows into the rotated bitmap blitter,
// starting with directed rows for every placement and the clipping,
// saturation and transparency corners, then random bitmaps under changing
// sender and receiver stalls. A checker beside the block scores each write.
// ----------------------------------------------------------------------------
module tb_rotated_bitmap_blitter;
    import rbb_pkg::*;

    localparam int RANDOM_ROWS   = 110;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int ROWS_PER_BMP  = 12;
    localparam int WRAP_ROWS     = 66;

    typedef struct packed {
        logic        two_bit;
        logic [2:0]  rot;
        logic [4:0]  width;
        logic [6:0]  height;
        logic [8:0]  origin_x;
        logic [6:0]  origin_y;
        logic [23:0] color_one;
        logic [47:0] color_two_three;
    } blit_cfg_t;

    localparam blit_cfg_t RESET_CFG = '{
        two_bit: 1'b0, rot: ROT_NONE, width: 5'd16, height: 7'd16,
        origin_x: 9'd0, origin_y: 7'd0, color_one: 24'hFFFFFF, color_two_three: 48'd0
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [47:0] cfg_wdata = '0;
    logic        row_valid = 1'b0;
    logic        row_ready;
    in_item_t    row_item  = '0;
    logic        pix_valid;
    logic        pix_ready = 1'b0;
    out_item_t   pix_item;

    int fail_count;
    int writes_pending;
    int writes_checked;
    int send_idle_pct  = 12;
    int recv_idle_pct  = 50;
    int hold_asked     = 0;
    int hold_served    = 0;
    int rows_sent      = 0;
    int settings_used  = 0;
    int cycle_count    = 0;

    rotated_bitmap_blitter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_item  (row_item),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_item  (pix_item)
    );

    rbb_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .row_valid      (row_valid),
        .row_ready      (row_ready),
        .row_item       (row_item),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .pix_item       (pix_item),
        .fail_count     (fail_count),
        .writes_pending (writes_pending),
        .writes_checked (writes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // pixel side: random stalls plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                pix_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            pix_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic load_config(input blit_cfg_t c);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_TWO_BIT_MODE;
        cfg_wdata <= 48'(c.two_bit);
        @(posedge clk);
        cfg_addr  <= CFG_ROTATION;
        cfg_wdata <= 48'(c.rot);
        @(posedge clk);
        cfg_addr  <= CFG_WIDTH;
        cfg_wdata <= 48'(c.width);
        @(posedge clk);
        cfg_addr  <= CFG_HEIGHT;
        cfg_wdata <= 48'(c.height);
        @(posedge clk);
        cfg_addr  <= CFG_ORIGIN_X;
        cfg_wdata <= 48'(c.origin_x);
        @(posedge clk);
        cfg_addr  <= CFG_ORIGIN_Y;
        cfg_wdata <= 48'(c.origin_y);
        @(posedge clk);
        cfg_addr  <= CFG_COLOR_ONE;
        cfg_wdata <= 48'(c.color_one);
        @(posedge clk);
        cfg_addr  <= CFG_COLOR_TWO_THREE;
        cfg_wdata <= c.color_two_three;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    task automatic send_row(input logic [31:0] bits, input logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            row_valid <= 1'b0;
            @(posedge clk);
        end
        row_valid          <= 1'b1;
        row_item.row_bits  <= bits;
        row_item.first_row <= first;
        @(posedge clk);
        while (!row_ready)
            @(posedge clk);
        rows_sent++;
    endtask

    // stop offering rows, wait for every owed write, then wait out the settle time
    task automatic settle();
        row_valid <= 1'b0;
        @(posedge clk);
        while (writes_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic blit_cfg_t pick_config();
        blit_cfg_t c;
        c.two_bit = 1'($urandom_range(1));
        c.rot     = 3'($urandom_range(7));
        case ($urandom_range(9))
            0:       c.width = 5'd16;
            1:       c.width = 5'd1;
            2:       c.width = 5'($urandom_range(31, 17));
            3:       c.width = 5'd0;
            default: c.width = 5'($urandom_range(16, 1));
        endcase
        case ($urandom_range(13))
            0:       c.height = 7'($urandom_range(64, 20));
            1:       c.height = 7'($urandom_range(127, 65));
            2:       c.height = 7'd0;
            default: c.height = 7'($urandom_range(6, 1));
        endcase
        c.origin_x        = 9'($urandom);
        c.origin_y        = 7'($urandom);
        c.color_one       = 24'($urandom);
        c.color_two_three = {16'($urandom), 32'($urandom)};
        return c;
    endfunction

    function automatic logic [31:0] pick_bits();
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom & $urandom;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        blit_cfg_t c;
        int        n_rows;
        int        done_rows;
        int        random_start;
        int        bmp;
        logic      first;
        logic      wrap_done;
        logic [31:0] bits;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, full row, empty row, bits above the width
        load_config(RESET_CFG);
        send_row(32'hFFFF_FFFF, 1'b1);
        send_row(32'h0000_0000, 1'b0);
        send_row(32'hFFFF_0000, 1'b0);

        // 2bpp with every code, most negative origin, palette extremes
        c = RESET_CFG;
        c.two_bit         = 1'b1;
        c.rot             = ROT_180;
        c.height          = 7'd64;
        c.origin_x        = 9'h100;
        c.origin_y        = 7'h40;
        c.color_one       = 24'h000000;
        c.color_two_three = 48'hFFFF_FFFF_FFFF;
        settle();
        load_config(c);
        send_row(32'hFFFF_FFFF, 1'b1);
        send_row(32'h1B1B_E4E4, 1'b0);

        // every rotation code, origins at both extremes
        for (int r = 0; r < 8; r++)
        begin
            c = RESET_CFG;
            c.rot       = 3'(r);
            c.width     = 5'd5;
            c.height    = 7'd3;
            c.origin_x  = r[0] ? 9'h0FF : 9'h100;
            c.origin_y  = r[1] ? 7'h3F : 7'h40;
            c.color_one = 24'($urandom);
            settle();
            load_config(c);
            send_row(32'h0000_0017, 1'b1);
        end

        // width and height above their maximum saturate
        c = RESET_CFG;
        c.two_bit = 1'b1;
        c.width   = 5'd31;
        c.height  = 7'd127;
        settle();
        load_config(c);
        send_row(32'hFFFF_FFFF, 1'b1);

        // second row lies past a one-row bitmap
        c = RESET_CFG;
        c.height = 7'd1;
        settle();
        load_config(c);
        send_row($urandom, 1'b1);
        send_row(32'hFFFF_FFFF, 1'b0);

        // zero width, then zero height
        c = RESET_CFG;
        c.width = 5'd0;
        settle();
        load_config(c);
        send_row(32'hFFFF_FFFF, 1'b1);
        c = RESET_CFG;
        c.height = 7'd0;
        settle();
        load_config(c);
        send_row(32'hFFFF_FFFF, 1'b1);

        // second row falls off the bottom of the ring
        c = RESET_CFG;
        c.height   = 7'd64;
        c.origin_y = 7'h3F;
        settle();
        load_config(c);
        send_row(32'hFFFF_FFFF, 1'b1);
        send_row(32'hFFFF_FFFF, 1'b0);

        random_start = rows_sent;
        bmp          = 0;
        wrap_done    = 1'b0;
        while (rows_sent - random_start < RANDOM_ROWS)
        begin
            done_rows = rows_sent - random_start;
            if (done_rows >= 90)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (done_rows >= 20)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 12;
            end
            c = pick_config();
            n_rows = (c.height > 7'd64) ? 64 : int'(c.height);
            if (n_rows == 0)
                n_rows = 2;
            if (n_rows > ROWS_PER_BMP)
                n_rows = ROWS_PER_BMP;
            if (bmp == 0)
            begin
                // dense rows while the pixel side holds off
                c.width  = 5'd16;
                c.height = 7'd8;
                n_rows   = 8;
            end
            else if (done_rows >= 20 && !wrap_done)
            begin
                // run the row counter past 63 so it wraps
                c.width   = 5'($urandom_range(3, 1));
                c.height  = 7'd64;
                n_rows    = WRAP_ROWS;
                wrap_done = 1'b1;
            end
            settle();
            load_config(c);
            if (bmp == 0)
                hold_asked++;
            for (int i = 0; i < n_rows; i++)
            begin
                first = (i == 0);
                // occasional broken sequence: stray restart or missing one
                if (n_rows != WRAP_ROWS && $urandom_range(9) == 0)
                    first = 1'($urandom_range(1));
                bits = (bmp == 0) ? ($urandom | $urandom) : pick_bits();
                send_row(bits, first);
            end
            bmp++;
        end

        settle();
        $display("%0d row transfers, %0d pixel writes checked, %0d register settings",
                 rows_sent, writes_checked, settings_used);
        $display("covered 1bpp and 2bpp, all rotation codes, clipping, saturation, row wrap");
        if (fail_count == 0 && writes_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rbb_pkg.sv
design/rbb_setup.sv
design/rotated_bitmap_blitter.sv
bench/rbb_checker.sv
bench/tb_rotated_bitmap_blitter.sv
